// ===== src/khtt_pkg.sv =====
package khtt_pkg;

	localparam int KEY_W = 64;
	localparam int HANDLE_W = 48;
	localparam int OC_W = 3;
	localparam int LEAK_W = 32;
	localparam int LIVE_W = 7;
	localparam int HASH_W = 32;

	localparam int SLOTS_DEF = 64;
	localparam int HANDLE_BITS_DEF = 48;

	localparam logic [KEY_W-1:0] FIB_MUL = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [KEY_W-1:0] KEY_FREE = 64'h0;
	localparam logic [KEY_W-1:0] KEY_HELD = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_GRAVE = 64'hFFFF_FFFF_FFFF_FFFE;

	typedef enum logic [OC_W-1:0] {
		OC_STORED = 3'd0,
		OC_FREED = 3'd1,
		OC_DUP = 3'd2,
		OC_FULL = 3'd3,
		OC_RELEASED = 3'd4,
		OC_MISSING = 3'd5
	} outcome_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MOD,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic load;
		logic mul_en;
		logic [1:0] mul_idx;
		logic mod_en;
		logic chk;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic early;
		logic mod_last;
		logic chk_done;
		logic out_free;
	} sts_t;

endpackage

// ===== src/khtt_ram.sv =====
module khtt_ram #(
	parameter int WIDTH = 112,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== src/khtt_ctrl.sv =====
module khtt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  khtt_pkg::sts_t  sts,
	output khtt_pkg::cmd_t  cmd,
	output logic            in_stall
);

	khtt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= khtt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			khtt_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_d = khtt_pkg::ST_IDLE;
			end
			khtt_pkg::ST_IDLE: begin
				if (in_valid) state_d = sts.early ? khtt_pkg::ST_DONE : khtt_pkg::ST_MUL0;
			end
			khtt_pkg::ST_MUL0: state_d = khtt_pkg::ST_MUL1;
			khtt_pkg::ST_MUL1: state_d = khtt_pkg::ST_MUL2;
			khtt_pkg::ST_MUL2: state_d = khtt_pkg::ST_MOD;
			khtt_pkg::ST_MOD: begin
				if (sts.mod_last) state_d = khtt_pkg::ST_READ;
			end
			khtt_pkg::ST_READ: state_d = khtt_pkg::ST_CHECK;
			khtt_pkg::ST_CHECK: begin
				state_d = sts.chk_done ? khtt_pkg::ST_DONE : khtt_pkg::ST_READ;
			end
			khtt_pkg::ST_DONE: begin
				if (sts.out_free) state_d = khtt_pkg::ST_IDLE;
			end
			default: state_d = khtt_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			khtt_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
			khtt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			khtt_pkg::ST_MUL0: begin
				cmd.mul_en = 1'b1;
				cmd.mul_idx = 2'd0;
			end
			khtt_pkg::ST_MUL1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_idx = 2'd1;
			end
			khtt_pkg::ST_MUL2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_idx = 2'd2;
			end
			khtt_pkg::ST_MOD: cmd.mod_en = 1'b1;
			khtt_pkg::ST_READ: ;
			khtt_pkg::ST_CHECK: cmd.chk = 1'b1;
			khtt_pkg::ST_DONE: cmd.fin = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== src/khtt_dp.sv =====
module khtt_dp #(
	parameter int SLOTS = khtt_pkg::SLOTS_DEF,
	parameter int HANDLE_BITS = khtt_pkg::HANDLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  khtt_pkg::cmd_t                   cmd,
	output khtt_pkg::sts_t                   sts,
	input  logic                             op,
	input  logic [khtt_pkg::KEY_W-1:0]       key,
	input  logic [khtt_pkg::HANDLE_W-1:0]    block_handle,
	input  logic                             nothing_staged,
	input  logic                             nonblocking,
	input  logic                             already_complete,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [khtt_pkg::OC_W-1:0]        outcome,
	output logic                             success,
	output logic                             free_valid,
	output logic [khtt_pkg::HANDLE_W-1:0]    free_handle,
	output logic [khtt_pkg::LEAK_W-1:0]      leaks_so_far,
	output logic [khtt_pkg::LIVE_W-1:0]      live_entries
);

	localparam int AW = $clog2(SLOTS);
	localparam int RW = AW + 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int LW = (CW > khtt_pkg::LIVE_W) ? CW : khtt_pkg::LIVE_W;
	localparam int SW = (HANDLE_BITS < khtt_pkg::HANDLE_W) ? HANDLE_BITS : khtt_pkg::HANDLE_W;
	localparam int MW = khtt_pkg::KEY_W + SW;
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

	logic                         op_q;
	logic [khtt_pkg::KEY_W-1:0]   key_q;
	logic [SW-1:0]                handle_q;
	logic [khtt_pkg::HASH_W-1:0]  acc_q;
	logic [RW-1:0]                rem_q, rem_d;
	logic [2:0]                   modcnt_q;
	logic [AW-1:0]                slot_q, probe_q, clr_q;
	logic [LW-1:0]                live_q;
	logic [khtt_pkg::LEAK_W-1:0]  leak_q;
	khtt_pkg::outcome_t           res_oc_q;
	logic [khtt_pkg::HANDLE_W-1:0] res_fh_q;

	logic                         out_v_q;
	khtt_pkg::outcome_t           out_oc_q;
	logic [khtt_pkg::HANDLE_W-1:0] out_fh_q;
	logic [khtt_pkg::LEAK_W-1:0]  out_leak_q;
	logic [khtt_pkg::LIVE_W-1:0]  out_live_q;

	logic [MW-1:0]                ram_wdata, ram_rdata;
	logic [AW-1:0]                ram_addr;
	logic                         ram_we;

	logic in_reserved, in_free_now;
	logic [khtt_pkg::HASH_W-1:0] mul_a, mul_b;
	logic [2*khtt_pkg::HASH_W-1:0] prod;
	logic [3:0] nib;

	logic [khtt_pkg::KEY_W-1:0] rd_key;
	logic [SW-1:0]              rd_handle;
	logic chk_done, chk_wr, chk_leak, chk_inc, chk_dec;
	khtt_pkg::outcome_t chk_oc;
	logic [khtt_pkg::HANDLE_W-1:0] chk_fh;
	logic [khtt_pkg::KEY_W-1:0] chk_wkey;

	assign in_reserved = (key == khtt_pkg::KEY_FREE) || (key == khtt_pkg::KEY_HELD) ||
		(key == khtt_pkg::KEY_GRAVE);
	assign in_free_now = nothing_staged || (nonblocking && already_complete);

	// multiply-shift hash, upper half of the low 64 product bits, one partial product a cycle
	assign mul_a = (cmd.mul_idx == 2'd1) ? key_q[63:32] : key_q[31:0];
	assign mul_b = (cmd.mul_idx == 2'd2) ? khtt_pkg::FIB_MUL[63:32] : khtt_pkg::FIB_MUL[31:0];
	assign prod = 64'(mul_a) * 64'(mul_b);

	// reduce the hash modulo SLOTS, four bits a cycle, msb first
	assign nib = 4'(acc_q >> {~modcnt_q, 2'b00});
	always_comb begin
		rem_d = rem_q;
		for (int i = 0; i < 4; i++) begin
			rem_d = {rem_d[RW-2:0], nib[3-i]};
			if (rem_d >= RW'(SLOTS)) rem_d = rem_d - RW'(SLOTS);
		end
	end

	assign rd_key = ram_rdata[MW-1:SW];
	assign rd_handle = ram_rdata[SW-1:0];

	always_comb begin
		chk_done = 1'b0;
		chk_wr = 1'b0;
		chk_leak = 1'b0;
		chk_inc = 1'b0;
		chk_dec = 1'b0;
		chk_oc = khtt_pkg::OC_MISSING;
		chk_fh = '0;
		chk_wkey = key_q;
		if (!op_q) begin
			if (rd_key == khtt_pkg::KEY_FREE || rd_key == khtt_pkg::KEY_GRAVE) begin
				chk_done = 1'b1;
				chk_wr = 1'b1;
				chk_inc = 1'b1;
				chk_oc = khtt_pkg::OC_STORED;
			end else if (rd_key == key_q) begin
				chk_done = 1'b1;
				chk_leak = 1'b1;
				chk_oc = khtt_pkg::OC_DUP;
			end else if (probe_q == LAST_SLOT) begin
				chk_done = 1'b1;
				chk_leak = 1'b1;
				chk_oc = khtt_pkg::OC_FULL;
			end
		end else begin
			chk_wkey = khtt_pkg::KEY_GRAVE;
			if (rd_key == khtt_pkg::KEY_FREE) begin
				chk_done = 1'b1;
			end else if (rd_key == key_q) begin
				chk_done = 1'b1;
				chk_wr = 1'b1;
				chk_dec = 1'b1;
				chk_oc = khtt_pkg::OC_RELEASED;
				chk_fh = khtt_pkg::HANDLE_W'(rd_handle);
			end else if (probe_q == LAST_SLOT) begin
				chk_done = 1'b1;
			end
		end
	end

	assign ram_we = cmd.clr_wr || (cmd.chk && chk_wr);
	assign ram_addr = cmd.clr_wr ? clr_q : slot_q;
	assign ram_wdata = cmd.clr_wr ? '0 : {chk_wkey, handle_q};

	khtt_ram #(
		.WIDTH(MW),
		.DEPTH(SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			live_q <= '0;
			leak_q <= '0;
			modcnt_q <= '0;
			probe_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cmd.load) begin
				modcnt_q <= '0;
				if (!op && !in_free_now && in_reserved && leak_q != '1) leak_q <= leak_q + 1'b1;
			end
			if (cmd.mod_en) begin
				modcnt_q <= modcnt_q + 1'b1;
				probe_q <= '0;
			end
			if (cmd.chk) begin
				if (chk_leak && leak_q != '1) leak_q <= leak_q + 1'b1;
				if (chk_inc) live_q <= live_q + 1'b1;
				if (chk_dec) live_q <= live_q - 1'b1;
				if (!chk_done) probe_q <= probe_q + 1'b1;
			end
			if (cmd.fin) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			key_q <= key;
			handle_q <= block_handle[SW-1:0];
			rem_q <= '0;
			res_fh_q <= '0;
			if (!op) begin
				if (in_free_now) begin
					res_oc_q <= khtt_pkg::OC_FREED;
					res_fh_q <= khtt_pkg::HANDLE_W'(block_handle[SW-1:0]);
				end else begin
					res_oc_q <= khtt_pkg::OC_DUP;
				end
			end else begin
				res_oc_q <= khtt_pkg::OC_MISSING;
			end
		end
		if (cmd.mul_en) begin
			if (cmd.mul_idx == 2'd0) begin
				acc_q <= prod[63:32];
			end else begin
				acc_q <= acc_q + prod[31:0];
			end
		end
		if (cmd.mod_en) begin
			rem_q <= rem_d;
			if (modcnt_q == 3'd7) slot_q <= rem_d[AW-1:0];
		end
		if (cmd.chk) begin
			if (!chk_done) begin
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			end else begin
				res_oc_q <= chk_oc;
				res_fh_q <= chk_fh;
			end
		end
		if (cmd.fin) begin
			out_oc_q <= res_oc_q;
			out_fh_q <= res_fh_q;
			out_leak_q <= leak_q;
			out_live_q <= live_q[khtt_pkg::LIVE_W-1:0];
		end
	end

	assign sts.clr_last = (clr_q == LAST_SLOT);
	assign sts.early = op ? ((live_q == '0) || in_reserved) : (in_free_now || in_reserved);
	assign sts.mod_last = (modcnt_q == 3'd7);
	assign sts.chk_done = chk_done;
	assign sts.out_free = !out_v_q || !out_stall;

	assign out_valid = out_v_q;
	assign outcome = out_oc_q;
	assign success = (out_oc_q != khtt_pkg::OC_FULL);
	assign free_valid = (out_oc_q == khtt_pkg::OC_FREED) || (out_oc_q == khtt_pkg::OC_RELEASED);
	assign free_handle = out_fh_q;
	assign leaks_so_far = out_leak_q;
	assign live_entries = out_live_q;

endmodule

// ===== src/keyed_handle_table_with_tombstones_unit.sv =====
// channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------------
// in       | in_valid / in_stall | op, key, block_handle, nothing_staged,
//          |                     | nonblocking, already_complete
// out      | out_valid/out_stall | outcome, success, free_valid, free_handle,
//          |                     | leaks_so_far, live_entries
//
// One item at a time. An item settled by policy alone goes straight to the hand-off; a probed item
// passes the hash multiply states MUL0, MUL1 and MUL2, the modulo reduction, then a read and a
// check per probed slot on the single-port slot memory, then the hand-off.
// After reset the slot memory is cleared, one slot a cycle, while in_stall is high. A finished
// result waits in the output register while the next item is taken; a stalled output holds
// the controller only when the next result is ready.
module keyed_handle_table_with_tombstones_unit #(
	parameter int SLOTS = khtt_pkg::SLOTS_DEF,
	parameter int HANDLE_BITS = khtt_pkg::HANDLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             op,
	input  logic [khtt_pkg::KEY_W-1:0]       key,
	input  logic [khtt_pkg::HANDLE_W-1:0]    block_handle,
	input  logic                             nothing_staged,
	input  logic                             nonblocking,
	input  logic                             already_complete,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [khtt_pkg::OC_W-1:0]        outcome,
	output logic                             success,
	output logic                             free_valid,
	output logic [khtt_pkg::HANDLE_W-1:0]    free_handle,
	output logic [khtt_pkg::LEAK_W-1:0]      leaks_so_far,
	output logic [khtt_pkg::LIVE_W-1:0]      live_entries
);

	khtt_pkg::cmd_t cmd;
	khtt_pkg::sts_t sts;

	khtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	khtt_dp #(
		.SLOTS       (SLOTS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.op               (op),
		.key              (key),
		.block_handle     (block_handle),
		.nothing_staged   (nothing_staged),
		.nonblocking      (nonblocking),
		.already_complete (already_complete),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.outcome          (outcome),
		.success          (success),
		.free_valid       (free_valid),
		.free_handle      (free_handle),
		.leaks_so_far     (leaks_so_far),
		.live_entries     (live_entries)
	);

endmodule

// ===== src/khtt_chk.sv =====
module khtt_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [khtt_pkg::OC_W-1:0]     outcome,
	input logic                          success,
	input logic                          free_valid,
	input logic [khtt_pkg::HANDLE_W-1:0] free_handle,
	input logic [khtt_pkg::LEAK_W-1:0]   leaks_so_far
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_success: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (success == (outcome != khtt_pkg::OC_FULL)))
		else $error("success disagrees with outcome");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (free_valid == (outcome == khtt_pkg::OC_FREED ||
			outcome == khtt_pkg::OC_RELEASED)))
		else $error("free_valid disagrees with outcome");

	a_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !free_valid |-> free_handle == '0)
		else $error("free_handle set without free_valid");

	a_leak_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall ##1 out_valid |-> leaks_so_far >= $past(leaks_so_far))
		else $error("leak count went down");

endmodule

bind keyed_handle_table_with_tombstones_unit khtt_chk u_khtt_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.outcome      (outcome),
	.success      (success),
	.free_valid   (free_valid),
	.free_handle  (free_handle),
	.leaks_so_far (leaks_so_far)
);

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import khtt_pkg::*;

	localparam int NSLOT = 64;

	typedef struct {
		logic op;
		logic [KEY_W-1:0] key;
		logic [HANDLE_W-1:0] hnd;
		logic ns;
		logic nb;
		logic ac;
	} req_t;

	typedef struct {
		outcome_t oc;
		logic success;
		logic free_valid;
		logic [HANDLE_W-1:0] free_handle;
		logic [LEAK_W-1:0] leaks;
		logic [LIVE_W-1:0] live;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b0;
	logic [KEY_W-1:0] key = '0;
	logic [HANDLE_W-1:0] block_handle = '0;
	logic nothing_staged = 1'b0;
	logic nonblocking = 1'b0;
	logic already_complete = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OC_W-1:0] outcome;
	logic success;
	logic free_valid;
	logic [HANDLE_W-1:0] free_handle;
	logic [LEAK_W-1:0] leaks_so_far;
	logic [LIVE_W-1:0] live_entries;

	keyed_handle_table_with_tombstones_unit dut (.*);

	// table mirror
	logic [KEY_W-1:0] mirror_key [NSLOT];
	logic [HANDLE_W-1:0] mirror_hnd [NSLOT];
	int unsigned mirror_live;
	logic [LEAK_W-1:0] mirror_leaks;

	verdict_t pending_verdicts[$];
	int errors;
	int items_sent;
	int results_seen;
	int outcome_hits [6];
	bit idle_on = 1'b1;
	int hold_req;
	int hold_left;
	logic [KEY_W-1:0] key_pool [48];

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(12ns * 900000);
		$display("Verification failed");
		$finish;
	end

	function automatic logic [5:0] home_of(logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] p;
		p = k * FIB_MUL;
		return p[37:32];
	endfunction

	function automatic bit reserved_key(logic [KEY_W-1:0] k);
		return k == KEY_FREE || k == KEY_HELD || k == KEY_GRAVE;
	endfunction

	function automatic verdict_t table_apply(req_t r);
		verdict_t v;
		logic [5:0] s;
		logic [KEY_W-1:0] k;
		bit stop;
		s = home_of(r.key);
		stop = 1'b0;
		v.free_handle = '0;
		if (!r.op) begin
			if (r.ns || (r.nb && r.ac)) begin
				v.oc = OC_FREED;
				v.free_handle = r.hnd;
			end else if (reserved_key(r.key)) begin
				v.oc = OC_DUP;
			end else begin
				v.oc = OC_FULL;
				for (int p = 0; p < NSLOT && !stop; p++) begin
					k = mirror_key[s];
					if (k == KEY_FREE || k == KEY_GRAVE) begin
						mirror_key[s] = r.key;
						mirror_hnd[s] = r.hnd;
						mirror_live++;
						v.oc = OC_STORED;
						stop = 1'b1;
					end else if (k == r.key) begin
						v.oc = OC_DUP;
						stop = 1'b1;
					end
					s = s + 1'b1;
				end
			end
			if ((v.oc == OC_DUP || v.oc == OC_FULL) && mirror_leaks != '1)
				mirror_leaks++;
		end else begin
			v.oc = OC_MISSING;
			if (mirror_live != 0 && !reserved_key(r.key)) begin
				for (int p = 0; p < NSLOT && !stop; p++) begin
					k = mirror_key[s];
					if (k == KEY_FREE) begin
						stop = 1'b1;
					end else if (k == r.key) begin
						v.free_handle = mirror_hnd[s];
						mirror_key[s] = KEY_GRAVE;
						mirror_live--;
						v.oc = OC_RELEASED;
						stop = 1'b1;
					end
					s = s + 1'b1;
				end
			end
		end
		v.success = v.oc != OC_FULL;
		v.free_valid = v.oc == OC_FREED || v.oc == OC_RELEASED;
		v.leaks = mirror_leaks;
		v.live = mirror_live[LIVE_W-1:0];
		return v;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch at result %0d: %s got %0h expected %0h", results_seen, field, got,
			want);
		errors++;
	endtask

	task automatic send_item(logic o, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h,
		logic n, logic b, logic c);
		req_t r;
		if (idle_on && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		op <= o;
		key <= k;
		block_handle <= h;
		nothing_staged <= n;
		nonblocking <= b;
		already_complete <= c;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		r.op = o;
		r.key = k;
		r.hnd = h;
		r.ns = n;
		r.nb = b;
		r.ac = c;
		pending_verdicts.push_back(table_apply(r));
		items_sent++;
	endtask

	// store a plain persistent keep
	task automatic keep_item(logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
		send_item(1'b0, k, h, 1'b0, 1'b0, $urandom_range(1));
	endtask

	task automatic release_item(logic [KEY_W-1:0] k);
		send_item(1'b1, k, {$urandom, $urandom}, $urandom_range(1), $urandom_range(1),
			$urandom_range(1));
	endtask

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// receive side: random stall, long hold on request, check each result
	always @(posedge clk) begin
		verdict_t v;
		if (out_valid && !out_stall) begin
			results_seen++;
			if (pending_verdicts.size() == 0) begin
				$display("unexpected result %0d, nothing pending", results_seen);
				errors++;
			end else begin
				v = pending_verdicts.pop_front();
				if (outcome < 6)
					outcome_hits[outcome]++;
				if (outcome !== v.oc) report_mismatch("outcome", outcome, v.oc);
				if (success !== v.success) report_mismatch("success", success, v.success);
				if (free_valid !== v.free_valid)
					report_mismatch("free_valid", free_valid, v.free_valid);
				if (free_handle !== v.free_handle)
					report_mismatch("free_handle", free_handle, v.free_handle);
				if (leaks_so_far !== v.leaks)
					report_mismatch("leaks_so_far", leaks_so_far, v.leaks);
				if (live_entries !== v.live)
					report_mismatch("live_entries", live_entries, v.live);
			end
		end
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_on && $urandom_range(99) < 16;
		end
	end

	task automatic test_policy();
		send_item(1'b0, 64'h1234, '1, 1'b1, 1'b0, 1'b0);
		send_item(1'b0, 64'h1234, '0, 1'b0, 1'b1, 1'b1);
		send_item(1'b0, KEY_FREE, 48'h5a5a, 1'b0, 1'b0, 1'b0);
		send_item(1'b0, KEY_HELD, 48'h1, 1'b0, 1'b1, 1'b0);
		send_item(1'b0, KEY_GRAVE, 48'h2, 1'b0, 1'b0, 1'b1);
		release_item(64'h77);
		send_item(1'b0, KEY_HELD - 2, '1, 1'b0, 1'b1, 1'b0);
		send_item(1'b0, 64'h1, '0, 1'b0, 1'b0, 1'b1);
		send_item(1'b0, 64'h1, 48'h3, 1'b0, 1'b0, 1'b0);
		release_item(KEY_HELD);
		release_item(KEY_FREE);
		release_item(KEY_GRAVE);
		release_item(KEY_HELD - 2);
		release_item(64'h1);
		release_item(64'h1);
	endtask

	// a key stored again past a tombstone lands twice in the chain
	task automatic test_tombstone_chain();
		logic [KEY_W-1:0] a, b;
		a = rand_key();
		do b = rand_key(); while (home_of(b) != home_of(a) || b == a);
		keep_item(a, 48'h111);
		keep_item(b, 48'h222);
		release_item(a);
		keep_item(b, 48'h333);
		release_item(b);
		release_item(b);
		release_item(b);
	endtask

	task automatic test_full_table();
		logic [KEY_W-1:0] fill [NSLOT];
		for (int i = 0; i < NSLOT; i++) begin
			fill[i] = rand_key();
			keep_item(fill[i], {$urandom, $urandom});
		end
		keep_item(rand_key(), 48'hdead);
		keep_item(fill[5], 48'hbeef);
		release_item(rand_key());
		for (int i = 0; i < NSLOT; i++)
			release_item(fill[i]);
	endtask

	// receiver holds off while items keep coming
	task automatic test_backpressure();
		hold_req = 400;
		for (int i = 0; i < 20; i++)
			keep_item(key_pool[i], {$urandom, $urandom});
		for (int i = 0; i < 20; i++)
			release_item(key_pool[i]);
	endtask

	task automatic test_random(int count);
		int sel;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < count; i++) begin
			idle_on = !(i >= count / 3 && i < count / 2);
			sel = $urandom_range(99);
			if (sel < 85)
				k = key_pool[$urandom_range(47)];
			else if (sel < 97)
				k = rand_key();
			else
				k = (sel == 97) ? KEY_FREE : (sel == 98) ? KEY_HELD : KEY_GRAVE;
			if ($urandom_range(99) < 45)
				release_item(k);
			else if ($urandom_range(99) < 80)
				send_item(1'b0, k, {$urandom, $urandom}, 1'b0, $urandom_range(1),
					$urandom_range(1) & $urandom_range(1));
			else
				send_item(1'b0, k, {$urandom, $urandom}, $urandom_range(1),
					$urandom_range(1), $urandom_range(1));
		end
		idle_on = 1'b1;
	endtask

	initial begin
		int guard;
		for (int i = 0; i < NSLOT; i++) begin
			mirror_key[i] = KEY_FREE;
			mirror_hnd[i] = '0;
		end
		mirror_leaks = '0;
		for (int i = 0; i < 48; i++)
			key_pool[i] = rand_key();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_policy();
		test_tombstone_chain();
		test_full_table();
		test_backpressure();
		test_random(1357);
		in_valid <= 1'b0;
		guard = 0;
		while (pending_verdicts.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			$display("%0d results never arrived", pending_verdicts.size());
			errors++;
		end
		$display("sent %0d items, checked %0d results, %0d mismatches", items_sent,
			results_seen, errors);
		$display("outcomes stored/freed/dup/full/released/missing: %0d %0d %0d %0d %0d %0d",
			outcome_hits[0], outcome_hits[1], outcome_hits[2], outcome_hits[3],
			outcome_hits[4], outcome_hits[5]);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
